>>> design/pfb_pkg.sv
// Shared constants, types and functions of the paged framebuffer tile blitter.
package pfb_pkg;

   // Screen and store geometry.
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int TILE_COUNT    = 256;
   localparam int PAGE_COUNT    = SCREEN_HEIGHT / 8;
   localparam int FRAME_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
   localparam int TILE_BYTES    = 2048;

   // Address and index widths.
   localparam int FRAME_AW = $clog2(FRAME_BYTES);
   localparam int TILE_AW  = $clog2(TILE_BYTES);
   localparam int COL_AW   = $clog2(SCREEN_WIDTH);
   localparam int PAGE_AW  = $clog2(PAGE_COUNT + 1);

   // Reciprocal used to fold a tile index into the tile count.
   localparam int TILE_RECIP = (1 << 16) / TILE_COUNT;

   // Action codes.
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_DRAW = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // Color codes; any other code inverts.
   localparam logic [1:0] COLOR_BLACK = 2'd0;
   localparam logic [1:0] COLOR_WHITE = 2'd1;

   // Controls for shaping one tile column into one page part.
   typedef struct packed {
      logic       mirror_v;
      logic [2:0] shift;
      logic       upper;
   } col_ctl_type;

   // Combines the target byte with the tile bits for the given color.
   function automatic logic [7:0] merge_byte(input logic [7:0] old_byte,
                                             input logic [7:0] bits,
                                             input logic [1:0] color);
      logic [7:0] result;
      case (color)
         COLOR_BLACK: begin
            result = old_byte & ~bits;
         end
         COLOR_WHITE: begin
            result = old_byte | bits;
         end
         default: begin
            result = old_byte ^ bits;
         end
      endcase
      return result;
   endfunction

endpackage

>>> design/paged_framebuffer_tile_blitter.sv
// Top level of the paged framebuffer tile blitter: sequencer, tile store and frame store.
//
// Draws 8x8 one-bit tiles into a 128x64 monochrome framebuffer whose bytes each hold 8
// vertical pixels, loads the tile store byte by byte, and reads back single frame bytes.
// Every item gives one result item. After reset a clearing pass writes zero to all 1024
// frame bytes, one a cycle, and no item is taken during the pass. A load, an unused
// action or a rejected draw goes from acceptance straight to the finish state, a read
// first passes a read state, and a visible draw passes a preparation state that folds
// the tile index, then 16 read-modify-write steps (two page parts for each of 8 columns)
// through the single read port and single write port of the frame store, then a drain
// state that lets the last write land. The next item is accepted as soon as the result has
// moved into the output register, even while that result still waits to be taken.
module paged_framebuffer_tile_blitter
   import pfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action [1:0]
   input  logic [1:0]  req_tuser,
   // pos_x [15:0], pos_y [31:16], tile_index [39:32], color [41:40], mirror_h [42],
   // mirror_v [43], address [54:44], data_byte [62:55], zero [63]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data [7:0], tile_visible [8], zero [15:9]
   output logic [15:0] rsp_tdata
);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [16:0] RECIP_V = 17'(TILE_RECIP);

   // Input item fields.
   logic [1:0]         req_action;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic [7:0]         req_tile_index;
   logic [1:0]         req_color;
   logic               req_mirror_h;
   logic               req_mirror_v;
   logic [10:0]        req_address;
   logic [7:0]         req_data_byte;

   assign req_action     = req_tuser[1:0];
   assign req_pos_x      = req_tdata[15:0];
   assign req_pos_y      = req_tdata[31:16];
   assign req_tile_index = req_tdata[39:32];
   assign req_color      = req_tdata[41:40];
   assign req_mirror_h   = req_tdata[42];
   assign req_mirror_v   = req_tdata[43];
   assign req_address    = req_tdata[54:44];
   assign req_data_byte  = req_tdata[62:55];

   // Control state.
   logic [2:0]          state_ff, state_in;
   logic [FRAME_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [3:0]          step_ff, step_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // Payload registers.
   logic signed [15:0]  x_ff;
   logic signed [15:0]  page_ff;
   logic [2:0]          shift_ff;
   logic [1:0]          color_ff;
   logic                mh_ff;
   logic                mv_ff;
   logic [7:0]          tile_idx_ff;
   logic [8:0]          tile_q_ff;
   logic [TILE_AW-1:0]  tile_base_ff;
   logic                rd_ok_ff;
   logic [7:0]          res_data_ff;
   logic                res_vis_ff;
   logic [FRAME_AW-1:0] s1_addr_ff;
   col_ctl_type         s1_ctl_ff;
   logic [15:0]         rsp_data_ff;

   // Memories and their ports.
   logic [7:0]          frame_mem [FRAME_BYTES];
   logic [7:0]          tile_mem  [TILE_BYTES];
   logic [7:0]          frame_rd_ff;
   logic [7:0]          tile_rd_ff;
   logic                fm_we;
   logic [FRAME_AW-1:0] fm_waddr;
   logic [7:0]          fm_wdata;
   logic [FRAME_AW-1:0] fm_raddr;
   logic                tile_we;
   logic [TILE_AW-1:0]  tile_raddr;

   // Handshake and decode of the accepted item.
   logic req_fire;
   logic rsp_free;
   logic req_visible;
   logic req_rd_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_visible = !(req_pos_x < -16'sd8 || req_pos_x >= SCREEN_WIDTH ||
                          req_pos_y < -16'sd8 || req_pos_y >= SCREEN_HEIGHT);
   assign req_rd_ok   = req_address < FRAME_BYTES;

   // Tile index fold: estimate the quotient by reciprocal, then one compare and subtract.
   logic [24:0] tile_prod;
   logic [16:0] tile_qd;
   logic [16:0] tile_rem_raw;
   logic [16:0] tile_rem;

   assign tile_prod    = {9'b0, req_tile_index} * {8'b0, RECIP_V};
   assign tile_qd      = 17'(tile_q_ff * 17'(TILE_COUNT));
   assign tile_rem_raw = {9'b0, tile_idx_ff} - tile_qd;
   assign tile_rem     = (tile_rem_raw >= 17'(TILE_COUNT)) ?
                         tile_rem_raw - 17'(TILE_COUNT) : tile_rem_raw;

   // Target of the current draw step: column step/2, page part step%2.
   logic [2:0]         step_col;
   logic signed [16:0] col_s;
   logic signed [16:0] page_s;
   logic               step_hit;
   logic [FRAME_AW-1:0] step_addr;

   assign step_col = step_ff[3:1];
   assign col_s    = {x_ff[15], x_ff} + {14'b0, step_col};
   assign page_s   = {page_ff[15], page_ff} + {16'b0, step_ff[0]};
   assign step_hit = (col_s >= 0) && (col_s < SCREEN_WIDTH) &&
                     (page_s >= 0) && (page_s < PAGE_COUNT) &&
                     (!step_ff[0] || shift_ff != 3'd0);
   assign step_addr = FRAME_AW'(int'(page_s[PAGE_AW-1:0]) * SCREEN_WIDTH +
                                int'(col_s[COL_AW-1:0]));
   assign tile_raddr = tile_base_ff | {{(TILE_AW - 3){1'b0}}, step_col ^ {3{mh_ff}}};

   // Merge stage: shape the tile column and combine it with the frame byte just read.
   logic [7:0] part_bits;

   pfb_col_unit u_col (
      .tile_byte (tile_rd_ff),
      .ctl       (s1_ctl_ff),
      .part_bits (part_bits)
   );

   // Frame store ports: the clearing pass and the merge stage share the write port.
   assign fm_we    = (state_ff == ST_CLEAR) || s1_valid_ff;
   assign fm_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : s1_addr_ff;
   assign fm_wdata = (state_ff == ST_CLEAR) ? 8'h00 :
                     merge_byte(frame_rd_ff, part_bits, color_ff);
   assign fm_raddr = (state_ff == ST_DRAW) ? step_addr : req_address[FRAME_AW-1:0];
   assign tile_we  = req_fire && (req_action == ACT_LOAD);

   always_ff @(posedge clock) begin
      if (fm_we) begin
         frame_mem[fm_waddr] <= fm_wdata;
      end
      frame_rd_ff <= frame_mem[fm_raddr];
   end

   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_mem[req_address] <= req_data_byte;
      end
      tile_rd_ff <= tile_mem[tile_raddr];
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      step_in       = step_ff;
      s1_valid_in   = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == FRAME_AW'(FRAME_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_DRAW && req_visible) begin
                  state_in = ST_PREP;
               end else if (req_action == ACT_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PREP: begin
            step_in  = 4'd0;
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            s1_valid_in = step_hit;
            step_in     = step_ff + 1'b1;
            if (step_ff == 4'd15) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         step_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         step_ff       <= step_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers: draw parameters, merge stage and results.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff        <= req_pos_x;
         page_ff     <= req_pos_y >>> 3;
         shift_ff    <= req_pos_y[2:0];
         color_ff    <= req_color;
         mh_ff       <= req_mirror_h;
         mv_ff       <= req_mirror_v;
         tile_idx_ff <= req_tile_index;
         tile_q_ff   <= tile_prod[24:16];
         rd_ok_ff    <= req_rd_ok;
         res_data_ff <= 8'h00;
         res_vis_ff  <= (req_action == ACT_DRAW) && req_visible;
      end
      if (state_ff == ST_PREP) begin
         tile_base_ff <= {tile_rem[7:0], 3'b000};
      end
      if (state_ff == ST_READ) begin
         res_data_ff <= rd_ok_ff ? frame_rd_ff : 8'h00;
      end
      s1_addr_ff <= step_addr;
      s1_ctl_ff  <= '{mirror_v: mv_ff, shift: shift_ff, upper: step_ff[0]};
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_data_ff <= {7'b0, res_vis_ff, res_data_ff};
      end
   end

   // The clearing pass owns the frame store: no item may enter during it.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("item accepted during the frame clearing pass");

   // Frame writes from the merge stage belong to a draw in progress.
   a_merge_in_draw: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == ST_DRAW || state_ff == ST_DRAIN))
      else $error("merge stage write outside a draw");

   // The last write of a draw lands before the result is handed on.
   a_drain_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_FINISH))
      else $error("draw did not finish after draining");

endmodule

>>> design/pfb_col_unit.sv
// Column shaper: optional vertical mirror, then the page shift and the page-part select.
module pfb_col_unit
   import pfb_pkg::*;
(
   input  logic [7:0]  tile_byte,
   input  col_ctl_type ctl,
   output logic [7:0]  part_bits
);

   logic [7:0]  flipped;
   logic [15:0] shifted;

   // Bit 0 is the top row, so a vertical mirror reverses the byte.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         flipped[k] = ctl.mirror_v ? tile_byte[7 - k] : tile_byte[k];
      end
   end

   // The column moves down by the row offset inside the page and spills into the next page.
   assign shifted   = {8'b0, flipped} << ctl.shift;
   assign part_bits = ctl.upper ? shifted[15:8] : shifted[7:0];

endmodule

>>> sim/tb.sv
// Self-checking testbench of the paged framebuffer tile blitter.
`timescale 1ns / 100ps

module tb;
   import pfb_pkg::*;

   // Run control.
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_GOAL   = 550;
   localparam int TAIL_CYCLES = 40;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] ACT_SPARE    = 2'd3;
   localparam logic [1:0] COLOR_INVERT = 2'd2;
   localparam logic [1:0] COLOR_SPARE  = 2'd3;

   // One request item, field by field.
   typedef struct {
      logic [1:0]         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         tile_index;
      logic [1:0]         color;
      logic               mirror_h;
      logic               mirror_v;
      logic [10:0]        address;
      logic [7:0]         data_byte;
   } blit_req_type;

   // One result item.
   typedef struct {
      logic [7:0] read_data;
      logic       tile_visible;
   } blit_rsp_type;

   // One row of the directed stimulus; fixed rows carry their result.
   typedef struct {
      blit_req_type req;
      bit           fixed;
      blit_rsp_type rsp;
   } blit_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // action [1:0]
   logic [1:0]  req_tuser;
   // pos_x [15:0], pos_y [31:16], tile_index [39:32], color [41:40], mirror_h [42],
   // mirror_v [43], address [54:44], data_byte [62:55], zero [63]
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // read_data [7:0], tile_visible [8], zero [15:9]
   logic [15:0] rsp_tdata;

   // Shadow copies of the frame and tile stores.
   logic [7:0] frame_img [FRAME_BYTES];
   logic [7:0] tile_img [TILE_BYTES];
   bit         tile_written [TILE_BYTES];
   bit         tile_ready [TILE_COUNT];
   int         ready_tiles [$];

   blit_rsp_type rsp_due [$];
   blit_row_type directed_rows [$];

   int errors;
   int n_sent;
   int n_loads;
   int n_draws;
   int n_visible;
   int n_reads;
   int n_spare;
   int n_checked;
   int idle_cycles;
   int stall_left;
   bit calm;

   paged_framebuffer_tile_blitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with an 8 ns period.
   always #4 clock = ~clock;

   // Gap length: mostly none, some short, a few long; none at all in calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request with every field random.
   function automatic blit_req_type random_req();
      blit_req_type it;
      it.action     = 2'($urandom);
      it.pos_x      = 16'($urandom);
      it.pos_y      = 16'($urandom);
      it.tile_index = 8'($urandom);
      it.color      = 2'($urandom);
      it.mirror_h   = 1'($urandom);
      it.mirror_v   = 1'($urandom);
      it.address    = 11'($urandom);
      it.data_byte  = 8'($urandom);
      return it;
   endfunction

   // Combines one page part of a tile column into the shadow frame.
   function automatic void paint_byte(input int page, input int col, input logic [7:0] bits,
                                      input logic [1:0] color);
      int idx;
      if (page < 0 || page >= PAGE_COUNT || col < 0 || col >= SCREEN_WIDTH)
         return;
      idx = page * SCREEN_WIDTH + col;
      if (color == COLOR_WHITE)
         frame_img[idx] = frame_img[idx] | bits;
      else if (color == COLOR_BLACK)
         frame_img[idx] = frame_img[idx] & ~bits;
      else
         frame_img[idx] = frame_img[idx] ^ bits;
   endfunction

   // Applies one item to the shadow stores and returns the result it gives.
   function automatic blit_rsp_type blit_predict(input blit_req_type it);
      blit_rsp_type r;
      int           x;
      int           y;
      int           shift;
      int           page;
      int           base;
      int           col;
      int           i;
      int           k;
      int           t;
      bit           whole;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [15:0]  wide;
      r.read_data    = 8'd0;
      r.tile_visible = 1'b0;
      x = it.pos_x;
      y = it.pos_y;
      case (it.action)
         ACT_LOAD: begin
            tile_img[it.address] = it.data_byte;
            tile_written[it.address] = 1'b1;
            // A tile becomes drawable once all eight of its bytes are loaded.
            t = int'(it.address) / 8;
            if (!tile_ready[t]) begin
               whole = 1'b1;
               for (k = 0; k < 8; k++)
                  whole = whole & tile_written[t * 8 + k];
               if (whole) begin
                  tile_ready[t] = 1'b1;
                  ready_tiles.push_back(t);
               end
            end
         end
         ACT_DRAW: begin
            if (!(x + 8 < 0 || x >= SCREEN_WIDTH || y + 8 < 0 || y >= SCREEN_HEIGHT)) begin
               r.tile_visible = 1'b1;
               base  = (int'(it.tile_index) % TILE_COUNT) * 8;
               shift = y & 7;
               page  = y >>> 3;
               for (i = 0; i < 8; i++) begin
                  col = x + i;
                  if (col >= 0 && col < SCREEN_WIDTH) begin
                     a = tile_img[(base + (it.mirror_h ? 7 - i : i)) % TILE_BYTES];
                     if (it.mirror_v) begin
                        for (k = 0; k < 8; k++)
                           b[k] = a[7 - k];
                        a = b;
                     end
                     wide = {8'd0, a} << shift;
                     paint_byte(page, col, wide[7:0], it.color);
                     if (shift != 0)
                        paint_byte(page + 1, col, wide[15:8], it.color);
                  end
               end
            end
         end
         ACT_READ: begin
            if (int'(it.address) < FRAME_BYTES)
               r.read_data = frame_img[it.address];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Offers one item after a random gap and books its result once it is taken.
   task automatic send_item(input blit_req_type it, input bit fixed,
                            input blit_rsp_type fixed_rsp);
      int           gap;
      blit_rsp_type due;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = it.action;
      req_tdata  = {1'b0, it.data_byte, it.address, it.mirror_v, it.mirror_h, it.color,
                    it.tile_index, it.pos_y, it.pos_x};
      do @(posedge clock); while (!req_tready);
      due = blit_predict(it);
      if (fixed)
         due = fixed_rsp;
      rsp_due.push_back(due);
      n_sent++;
      case (it.action)
         ACT_LOAD: n_loads++;
         ACT_DRAW: begin
            n_draws++;
            n_visible += due.tile_visible;
         end
         ACT_READ: n_reads++;
         default: n_spare++;
      endcase
   endtask

   // Appends one directed row.
   task automatic add_row(input logic [1:0] action, input int x, input int y,
                          input logic [7:0] tile, input logic [1:0] color,
                          input logic mh, input logic mv, input logic [10:0] addr,
                          input logic [7:0] data, input bit fixed,
                          input logic [7:0] rd, input logic vis);
      blit_row_type row;
      row.req.action     = action;
      row.req.pos_x      = 16'(x);
      row.req.pos_y      = 16'(y);
      row.req.tile_index = tile;
      row.req.color      = color;
      row.req.mirror_h   = mh;
      row.req.mirror_v   = mv;
      row.req.address    = addr;
      row.req.data_byte  = data;
      row.fixed          = fixed;
      row.rsp.read_data  = rd;
      row.rsp.tile_visible = vis;
      directed_rows.push_back(row);
   endtask

   // Result side: random stalls, with calm stretches where it always takes.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   // Compare each result taken with the oldest booked one.
   always @(posedge clock) begin : check_rsp
      blit_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            errors++;
            $error("result item with nothing outstanding: rsp_tdata %h", rsp_tdata);
         end else begin
            want = rsp_due.pop_front();
            n_checked++;
            if (rsp_tdata[7:0] !== want.read_data) begin
               errors++;
               $error("read_data: expected %h, actual %h", want.read_data, rsp_tdata[7:0]);
            end
            if (rsp_tdata[8] !== want.tile_visible) begin
               errors++;
               $error("tile_visible: expected %b, actual %b", want.tile_visible, rsp_tdata[8]);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake; covers the clearing pass after reset.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
                  STALL_LIMIT, rsp_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus: directed rows first, then random traffic.
   initial begin
      blit_req_type it;
      blit_rsp_type no_rsp;
      int           r;
      int           t;
      int           k;
      int           i;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 2'd0;
      req_tdata   = 64'd0;
      rsp_tready  = 1'b0;
      errors      = 0;
      n_sent      = 0;
      n_loads     = 0;
      n_draws     = 0;
      n_visible   = 0;
      n_reads     = 0;
      n_spare     = 0;
      n_checked   = 0;
      idle_cycles = 0;
      stall_left  = 0;
      calm        = 1'b0;
      no_rsp.read_data    = 8'd0;
      no_rsp.tile_visible = 1'b0;
      for (i = 0; i < FRAME_BYTES; i++)
         frame_img[i] = 8'd0;
      for (i = 0; i < TILE_BYTES; i++) begin
         tile_img[i] = 8'd0;
         tile_written[i] = 1'b0;
      end
      for (i = 0; i < TILE_COUNT; i++)
         tile_ready[i] = 1'b0;

      // Cleared screen, including the first and last frame byte and beyond the frame.
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd0, 8'd0, 1, 8'd0, 0);
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd1023, 8'd0, 1, 8'd0, 0);
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2047, 8'd0, 1, 8'd0, 0);
      // The last tile of the store, with extreme and asymmetric column bytes.
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2040, 8'h01, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2041, 8'h80, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2042, 8'hFF, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2043, 8'h00, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2044, 8'hA5, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2045, 8'h3C, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2046, 8'h0F, 1, 8'd0, 0);
      add_row(ACT_LOAD, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd2047, 8'hF0, 1, 8'd0, 0);
      // Aligned draw at the origin.
      add_row(ACT_DRAW, 0, 0, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 0, 8'd0, 0);
      // Tiles just on or just past each screen edge.
      add_row(ACT_DRAW, -8, 0, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 1, 8'd0, 1);
      add_row(ACT_DRAW, -9, 0, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 1, 8'd0, 0);
      add_row(ACT_DRAW, 128, 0, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 1, 8'd0, 0);
      add_row(ACT_DRAW, 0, -8, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 1, 8'd0, 1);
      add_row(ACT_DRAW, 0, 64, 8'd255, COLOR_WHITE, 0, 0, 11'd0, 8'd0, 1, 8'd0, 0);
      add_row(ACT_DRAW, -32768, 32767, 8'd255, COLOR_WHITE, 1, 1, 11'd0, 8'd0, 1, 8'd0, 0);
      add_row(ACT_DRAW, 32767, -32768, 8'd255, COLOR_WHITE, 1, 1, 11'd0, 8'd0, 1, 8'd0, 0);
      // Partial tiles split over two pages, the black, invert and spare color codes and both mirrors.
      add_row(ACT_DRAW, 127, 60, 8'd255, COLOR_INVERT, 1, 1, 11'd0, 8'd0, 0, 8'd0, 0);
      add_row(ACT_DRAW, 3, -3, 8'd255, COLOR_BLACK, 1, 0, 11'd0, 8'd0, 0, 8'd0, 0);
      add_row(ACT_DRAW, 120, 61, 8'd255, COLOR_SPARE, 0, 1, 11'd0, 8'd0, 0, 8'd0, 0);
      // Unused action code with every field high.
      add_row(ACT_SPARE, -1, -1, 8'd255, COLOR_SPARE, 1, 1, 11'd2047, 8'hFF, 1, 8'd0, 0);
      // Read back what the draws left, and the first address past the frame.
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd0, 8'd0, 0, 8'd0, 0);
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd1023, 8'd0, 0, 8'd0, 0);
      add_row(ACT_READ, 0, 0, 8'd0, COLOR_BLACK, 0, 0, 11'd1024, 8'd0, 1, 8'd0, 0);

      // Hold reset, then release it on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

      // Random traffic: whole tile loads feed draws of loaded tiles; the rest is noise.
      while (n_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 79) == 0)
            calm = !calm;
         r  = $urandom_range(0, 99);
         it = random_req();
         if (r < 12) begin
            t = $urandom_range(0, TILE_COUNT - 1);
            for (k = 0; k < 8; k++) begin
               it = random_req();
               it.action  = ACT_LOAD;
               it.address = 11'(t * 8 + k);
               send_item(it, 1'b0, no_rsp);
            end
         end else if (r < 17) begin
            it.action = ACT_LOAD;
            send_item(it, 1'b0, no_rsp);
         end else if (r < 60) begin
            it.action     = ACT_DRAW;
            it.tile_index = 8'(ready_tiles[$urandom_range(0, ready_tiles.size() - 1)]);
            // Mostly on or near the screen; the rest anywhere in the coordinate range.
            if ($urandom_range(0, 9) != 0) begin
               it.pos_x = 16'($urandom_range(0, 147) - 10);
               it.pos_y = 16'($urandom_range(0, 83) - 10);
            end
            send_item(it, 1'b0, no_rsp);
         end else if (r < 95) begin
            it.action = ACT_READ;
            if ($urandom_range(0, 5) != 0)
               it.address = 11'($urandom_range(0, FRAME_BYTES - 1));
            send_item(it, 1'b0, no_rsp);
         end else begin
            it.action = ACT_SPARE;
            send_item(it, 1'b0, no_rsp);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (rsp_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d draws (%0d on screen), %0d tile loads, %0d frame reads,",
               n_sent, n_draws, n_visible, n_loads, n_reads);
      $display("%0d unused-action items; %0d results compared, %0d mismatches.",
               n_spare, n_checked, errors);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
design/pfb_pkg.sv
design/pfb_col_unit.sv
design/paged_framebuffer_tile_blitter.sv
sim/tb.sv
